// ===== sv/dpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared widths, codes and types for the dual-pol power detector.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int MAX_INTEGRATION = 65536;
  localparam int LEN_W           = 17;  // integration_length register width
  localparam int CNT_W           = $clog2(MAX_INTEGRATION + 1);
  localparam int PROD_W          = 2 * SAMPLE_W;
  localparam int ACC_W           = PROD_W + $clog2(MAX_INTEGRATION);  // |X|^2, |Y|^2
  localparam int XACC_W          = ACC_W + 1;                         // cross terms
  localparam int PWR_W           = 50;
  localparam int CFG_W           = LEN_W;
  localparam int CFG_IDX_W       = 1;

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LEN    = 1'd1;

  // product_index codes
  typedef enum logic [1:0] {
    IDX_XX  = 2'd0,  // also total power
    IDX_YY  = 2'd1,
    IDX_XRE = 2'd2,
    IDX_XIM = 2'd3
  } prod_idx_t;

  typedef struct packed {
    logic             product_mode;
    logic [LEN_W-1:0] integ_len;
  } cfg_t;

  // one finished integration group
  typedef struct packed {
    logic                     four_prod;
    logic [ACC_W-1:0]         xx;
    logic [ACC_W-1:0]         yy;
    logic signed [XACC_W-1:0] cre;
    logic signed [XACC_W-1:0] cim;
  } grp_t;

  typedef struct packed {
    logic              valid;  // head entry present
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage : dpd_pkg
`default_nettype wire

// ===== sv/dpd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_front
// Sample intake: product pipeline, accumulators and group close detection.
// ----------------------------------------------------------------------------
module dpd_front (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  dpd_pkg::cfg_t                   cfg,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_x_re,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_x_im,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_y_re,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_y_im,
  input  wire                                   in_frame_end,
  input  wire  dpd_pkg::qstat_t                 qstat,
  output logic                                  push,
  output dpd_pkg::grp_t                         push_grp
);
  import dpd_pkg::*;

  // stage 1: registered sample
  logic                       v1_r;
  logic signed [SAMPLE_W-1:0] xr1_r, xi1_r, yr1_r, yi1_r;
  logic                       fend1_r;
  // stage 2: registered products
  logic                       v2_r;
  logic signed [PROD_W-1:0]   pxrxr_r, pxixi_r, pyryr_r, pyiyi_r;
  logic signed [PROD_W-1:0]   pxryr_r, pxiyi_r, pxiyr_r, pxryi_r;
  logic                       fend2_r;
  // accumulators
  logic [ACC_W-1:0]           acc_xx_r, acc_yy_r;
  logic signed [XACC_W-1:0]   acc_cre_r, acc_cim_r;
  logic [CNT_W-1:0]           cnt_r;

  logic [ACC_W-1:0]           acc_xx_nxt, acc_yy_nxt;
  logic signed [XACC_W-1:0]   acc_cre_nxt, acc_cim_nxt;
  logic [CNT_W-1:0]           cnt_inc;
  logic [LEN_W-1:0]           eff_len;
  logic                       close_grp;
  logic [QCNT_W:0]            in_flight;

  // credit check: every item in the pipe may still need a queue slot
  assign in_flight = {1'b0, qstat.count} + (QCNT_W + 1)'(v1_r) + (QCNT_W + 1)'(v2_r);
  assign in_stall  = (in_flight >= (QCNT_W + 1)'(Q_DEPTH));

  always_comb begin
    if (cfg.integ_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.integ_len > LEN_W'(MAX_INTEGRATION)) begin
      eff_len = LEN_W'(MAX_INTEGRATION);
    end else begin
      eff_len = cfg.integ_len;
    end
  end

  always_comb begin
    acc_xx_nxt  = acc_xx_r + ACC_W'(pxrxr_r) + ACC_W'(pxixi_r);
    acc_yy_nxt  = acc_yy_r + ACC_W'(pyryr_r) + ACC_W'(pyiyi_r);
    acc_cre_nxt = acc_cre_r + XACC_W'(pxryr_r) + XACC_W'(pxiyi_r);
    acc_cim_nxt = acc_cim_r + XACC_W'(pxiyr_r) - XACC_W'(pxryi_r);
    cnt_inc     = cnt_r + CNT_W'(1);
    close_grp   = v2_r && (LEN_W'(cnt_inc) >= eff_len);
  end

  assign push                = close_grp;
  assign push_grp.four_prod  = cfg.product_mode;
  assign push_grp.xx         = acc_xx_nxt;
  assign push_grp.yy         = acc_yy_nxt;
  assign push_grp.cre        = acc_cre_nxt;
  assign push_grp.cim        = acc_cim_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      acc_xx_r  <= '0;
      acc_yy_r  <= '0;
      acc_cre_r <= '0;
      acc_cim_r <= '0;
      cnt_r     <= '0;
    end else begin
      v1_r <= in_valid && !in_stall;
      v2_r <= v1_r;
      if (v2_r) begin
        if (close_grp || fend2_r) begin
          acc_xx_r  <= '0;
          acc_yy_r  <= '0;
          acc_cre_r <= '0;
          acc_cim_r <= '0;
          cnt_r     <= '0;
        end else begin
          acc_xx_r  <= acc_xx_nxt;
          acc_yy_r  <= acc_yy_nxt;
          acc_cre_r <= acc_cre_nxt;
          acc_cim_r <= acc_cim_nxt;
          cnt_r     <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    xr1_r   <= in_x_re;
    xi1_r   <= in_x_im;
    yr1_r   <= in_y_re;
    yi1_r   <= in_y_im;
    fend1_r <= in_frame_end;
    pxrxr_r <= PROD_W'(xr1_r) * PROD_W'(xr1_r);
    pxixi_r <= PROD_W'(xi1_r) * PROD_W'(xi1_r);
    pyryr_r <= PROD_W'(yr1_r) * PROD_W'(yr1_r);
    pyiyi_r <= PROD_W'(yi1_r) * PROD_W'(yi1_r);
    pxryr_r <= PROD_W'(xr1_r) * PROD_W'(yr1_r);
    pxiyi_r <= PROD_W'(xi1_r) * PROD_W'(yi1_r);
    pxiyr_r <= PROD_W'(xi1_r) * PROD_W'(yr1_r);
    pxryi_r <= PROD_W'(xr1_r) * PROD_W'(yi1_r);
    fend2_r <= fend1_r;
  end

endmodule : dpd_front
`default_nettype wire

// ===== sv/dpd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_queue
// Small FIFO of finished groups between intake and result serializer.
// ----------------------------------------------------------------------------
module dpd_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire  dpd_pkg::grp_t    push_grp,
  input  wire                    pop,
  output dpd_pkg::grp_t          head,
  output dpd_pkg::qstat_t        qstat
);
  import dpd_pkg::*;

  grp_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign do_pop      = pop && (cnt_r != '0);
  assign head        = mem[rd_ptr_r];
  assign qstat.valid = (cnt_r != '0);
  assign qstat.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign qstat.count = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_grp;
    end
  end

endmodule : dpd_queue
`default_nettype wire

// ===== sv/dpd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_back
// Result serializer: turns one group into one or four results, output reg.
// ----------------------------------------------------------------------------
module dpd_back (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  dpd_pkg::grp_t                   head,
  input  wire  dpd_pkg::qstat_t                 qstat,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [dpd_pkg::PWR_W-1:0]      out_power_value,
  output logic [1:0]                            out_product_index,
  output logic                                  out_run_last
);
  import dpd_pkg::*;

  logic                    out_valid_r;
  logic signed [PWR_W-1:0] pwr_r;
  prod_idx_t               idx_r;
  logic                    last_r;
  prod_idx_t               sub_r, sub_nxt;

  logic                    load;
  logic signed [PWR_W-1:0] pwr_nxt;
  prod_idx_t               idx_nxt;
  logic                    last_nxt;

  assign load = qstat.valid && (!out_valid_r || !out_stall);

  always_comb begin
    pwr_nxt  = PWR_W'(head.xx) + PWR_W'(head.yy);
    idx_nxt  = IDX_XX;
    last_nxt = 1'b1;
    sub_nxt  = IDX_XX;
    if (head.four_prod) begin
      idx_nxt  = sub_r;
      last_nxt = (sub_r == IDX_XIM);
      case (sub_r)
        IDX_XX: begin
          pwr_nxt = PWR_W'(head.xx);
          sub_nxt = IDX_YY;
        end
        IDX_YY: begin
          pwr_nxt = PWR_W'(head.yy);
          sub_nxt = IDX_XRE;
        end
        IDX_XRE: begin
          pwr_nxt = PWR_W'(head.cre);
          sub_nxt = IDX_XIM;
        end
        default: begin
          pwr_nxt = PWR_W'(head.cim);
          sub_nxt = IDX_XX;
        end
      endcase
    end
  end

  assign pop = load && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= IDX_XX;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= sub_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pwr_r  <= pwr_nxt;
      idx_r  <= idx_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_power_value   = pwr_r;
  assign out_product_index = idx_r;
  assign out_run_last      = last_r;

endmodule : dpd_back
`default_nettype wire

// ===== sv/dual_pol_power_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: the sample that closes a group passes the sample and product
//   registers, then the group queue, then the output register.
// Throughput: one sample per cycle while in_stall is low; results drain
//   one per cycle while out_stall is low, so in four-product mode with
//   short groups the output sets the rate via the 4-entry group queue.
// Reset: synchronous active-low rst_n clears accumulators, sample count,
//   pipeline valids, queue and output; product_mode=0, integration_length=1.
// ----------------------------------------------------------------------------
// dual_pol_power_detector_unit
// Dual-polarization power and cross-correlation detector, top level.
// ----------------------------------------------------------------------------
module dual_pol_power_detector_unit (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // config write port
  input  wire                                   cfg_we,
  input  wire  logic [dpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  logic [dpd_pkg::CFG_W-1:0]       cfg_wdata,
  // sample request channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_x_re,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_x_im,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_y_re,
  input  wire  logic signed [dpd_pkg::SAMPLE_W-1:0] in_y_im,
  input  wire                                   in_frame_end,
  // result request channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [dpd_pkg::PWR_W-1:0]      out_power_value,
  output logic [1:0]                            out_product_index,
  output logic                                  out_run_last
);
  import dpd_pkg::*;

  // Config registers. The user must write them only while the block is idle;
  // the block does not enforce it. The mode sampled at close applies to it.
  cfg_t   cfg_r;

  grp_t   push_grp, head;
  logic   push, pop;
  qstat_t qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.product_mode <= 1'b0;
      cfg_r.integ_len    <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRODUCT_MODE: cfg_r.product_mode <= cfg_wdata[0];
        REG_INTEG_LEN:    cfg_r.integ_len    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: two-stage product pipe, then accumulate and close groups.
  // It holds off new samples by credit, so a closing group always finds
  // a free queue slot.
  dpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_re      (in_x_re),
    .in_x_im      (in_x_im),
    .in_y_re      (in_y_re),
    .in_y_im      (in_y_im),
    .in_frame_end (in_frame_end),
    .qstat        (qstat),
    .push         (push),
    .push_grp     (push_grp)
  );

  // Group queue decouples intake from the result drain.
  dpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Back: serializes XX+YY or the four products into the output register.
  dpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_power_value   (out_power_value),
    .out_product_index (out_product_index),
    .out_run_last      (out_run_last)
  );

  // credit scheme must keep the queue from overflowing
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("group pushed into full queue");

  // a new result only comes out of a queued group
  a_rise_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(qstat.valid))
    else $error("result without queued group");

  // in product sequence only the imaginary cross term closes the group
  a_last_on_xim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_product_index != IDX_XX) |->
      (out_run_last == (out_product_index == IDX_XIM)))
    else $error("run_last misplaced");

  // an empty queue never pops
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.valid)
    else $error("pop from empty queue");

endmodule : dual_pol_power_detector_unit
`default_nettype wire

// ===== tb/dual_pol_power_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pol_power_detector_unit_tb
// Self-checking bench for the dual-pol power detector. A directed table
// covers sample extremes, short and out-of-range integration lengths, frame
// ends and mid-group register changes. A short full-scale run under an
// over-limit length follows, then random phases under random settings.
// Every accepted sample goes through a local model of the integrator. Each
// result request is checked in order against the queue of expected products.
// ----------------------------------------------------------------------------
module dual_pol_power_detector_unit_tb;
  import dpd_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_OFF      = 80;   // long receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = 8;    // margin for the pipe to empty
  localparam int USE_PREDICTOR = -1;   // table row: no typed expectation
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 22;
  localparam int CLAMP_ITEMS   = 8;
  localparam int PRESSURE_PHASE = 3;
  localparam int PAUSE_PHASE    = 5;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = ~S_MIN;

  // one result request as the block should emit it
  typedef struct {
    logic signed [PWR_W-1:0] value;
    prod_idx_t               idx;
    logic                    last;
  } power_t;

  // one row of the directed table: either a register write or a sample
  typedef struct {
    bit                          is_cfg;
    logic [CFG_IDX_W-1:0]        reg_idx;
    logic [CFG_W-1:0]            reg_val;
    logic signed [SAMPLE_W-1:0]  xr, xi, yr, yi;
    bit                          fend;
    int                          typed_n;      // USE_PREDICTOR, 0 or 1
    longint                      typed_total;  // total power when typed_n is 1
  } step_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]             cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_x_re = '0;
  logic signed [SAMPLE_W-1:0]   in_x_im = '0;
  logic signed [SAMPLE_W-1:0]   in_y_re = '0;
  logic signed [SAMPLE_W-1:0]   in_y_im = '0;
  logic                         in_frame_end = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [PWR_W-1:0]      out_power_value;
  logic [1:0]                   out_product_index;
  logic                         out_run_last;

  dual_pol_power_detector_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_x_re           (in_x_re),
    .in_x_im           (in_x_im),
    .in_y_re           (in_y_re),
    .in_y_im           (in_y_im),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_power_value   (out_power_value),
    .out_product_index (out_product_index),
    .out_run_last      (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Group products still owed by the block, oldest first.
  power_t expected_powers[$];
  int     mismatches = 0;
  int     cycle_count = 0;
  bit     no_idle = 1'b0;     // set for the closing stretch of the run
  bit     hold_req = 1'b0;    // sender asks the receiver for a long hold-off

  // Local integrator state; registers track the last write.
  longint                  sum_xx = 0;
  longint                  sum_yy = 0;
  longint                  sum_re = 0;
  longint                  sum_im = 0;
  int                      grp_count = 0;
  bit                      mode_sh = 1'b0;
  logic [LEN_W-1:0]        len_sh = LEN_W'(1);

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Adds one sample to the running group. Returns how many products the
  // sample releases; they land in res in emission order.
  function automatic int accumulate_sample(input logic signed [SAMPLE_W-1:0] xr, xi, yr, yi,
                                           input bit fend, output power_t res[4]);
    longint a, b, c, d, total;
    int     eff;
    int     n;
    a = longint'(xr);
    b = longint'(xi);
    c = longint'(yr);
    d = longint'(yi);
    sum_xx += a * a + b * b;
    sum_yy += c * c + d * d;
    sum_re += a * c + b * d;
    sum_im += b * c - a * d;
    grp_count++;
    // out-of-range lengths clamp into 1..MAX_INTEGRATION
    eff = int'(len_sh);
    if (eff < 1) eff = 1;
    if (eff > MAX_INTEGRATION) eff = MAX_INTEGRATION;
    n = 0;
    if (grp_count >= eff) begin
      // mode at the moment the group closes decides the format
      if (mode_sh) begin
        res[0] = '{value: sum_xx[PWR_W-1:0], idx: IDX_XX,  last: 1'b0};
        res[1] = '{value: sum_yy[PWR_W-1:0], idx: IDX_YY,  last: 1'b0};
        res[2] = '{value: sum_re[PWR_W-1:0], idx: IDX_XRE, last: 1'b0};
        res[3] = '{value: sum_im[PWR_W-1:0], idx: IDX_XIM, last: 1'b1};
        n = 4;
      end else begin
        total = sum_xx + sum_yy;
        res[0] = '{value: total[PWR_W-1:0], idx: IDX_XX, last: 1'b1};
        n = 1;
      end
    end
    // a closed group or a frame end both restart the integration
    if (n != 0 || fend) begin
      sum_xx = 0;
      sum_yy = 0;
      sum_re = 0;
      sum_im = 0;
      grp_count = 0;
    end
    return n;
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    step_t r;
    r = '{default: 0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = CFG_W'(val);
    return r;
  endfunction

  function automatic step_t sample_row(input int xr, xi, yr, yi, input bit fend,
                                       input int typed_n, input longint typed_total);
    step_t r;
    r = '{default: 0};
    r.xr = SAMPLE_W'(xr);
    r.xi = SAMPLE_W'(xi);
    r.yr = SAMPLE_W'(yr);
    r.yi = SAMPLE_W'(yi);
    r.fend = fend;
    r.typed_n = typed_n;
    r.typed_total = typed_total;
    return r;
  endfunction

  // Full-scale codes and zero show up often so the extremes get exercised.
  function automatic logic signed [SAMPLE_W-1:0] rand_field();
    case ($urandom_range(0, 7))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Register write. Called only with the block idle; we is a one-cycle
  // strobe, and the task returns only once it is low again, so back-to-back
  // writes never re-raise it in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_PRODUCT_MODE)
      mode_sh = val[0];
    else
      len_sh = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every owed result, then let a possibly
  // partial group finish its trip through the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one sample request, waits for it to be taken, then books the
  // products it releases. Entered and left right after a rising edge.
  task automatic feed_sample(input logic signed [SAMPLE_W-1:0] xr, xi, yr, yi,
                             input bit fend, input bit gaps,
                             input int typed_n, input longint typed_total);
    power_t res[4];
    int     n;
    if (gaps && !no_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_x_re      <= xr;
    in_x_im      <= xi;
    in_y_re      <= yr;
    in_y_im      <= yi;
    in_frame_end <= fend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = accumulate_sample(xr, xi, yr, yi, fend, res);
    if (typed_n == USE_PREDICTOR) begin
      for (int k = 0; k < n; k++) expected_powers.push_back(res[k]);
    end else if (typed_n == 1) begin
      expected_powers.push_back('{value: PWR_W'(typed_total), idx: IDX_XX, last: 1'b1});
    end
  endtask

  // Receiver: random stall bursts, calm stretches between them, and a long
  // hold-off on request so the group queue backs up.
  initial begin : result_stall
    int hold_left;
    int burst_left;
    int calm_left;
    hold_left  = 0;
    burst_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0 || no_idle) begin
        if (calm_left > 0) calm_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(10, 40);
        out_stall <= 1'b0;
      end
    end
  end

  // Each accepted result request is held against the oldest expectation.
  always @(posedge clk) begin : check_results
    power_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        flag_mismatch("result with none pending", longint'(out_power_value), 0);
      end else begin
        want = expected_powers.pop_front();
        if (out_power_value !== want.value)
          flag_mismatch("power_value", longint'(out_power_value), longint'(want.value));
        if (out_product_index !== want.idx)
          flag_mismatch("product_index", longint'(out_product_index), longint'(want.idx));
        if (out_run_last !== want.last)
          flag_mismatch("run_last", longint'(out_run_last), longint'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    step_t directed[$];
    step_t s;
    int    drain_wait;
    bit    mode_pick;
    int    len_pick;

    // Rows with a typed total are plain total-power cases that can be
    // worked out by hand; the rest go through the local integrator.
    directed = '{
      // reset state: total power, one sample per group
      sample_row(0, 0, 0, 0, 1'b0, 1, 0),
      sample_row(-32768, 0, 0, 0, 1'b0, 1, 64'd1073741824),
      sample_row(-32768, -32768, -32768, -32768, 1'b0, 1, 64'd4294967296),
      sample_row(32767, 32767, 32767, 32767, 1'b0, 1, 64'd4294705156),
      // frame end on a sample that closes its group still emits
      sample_row(32767, -32768, -32768, 32767, 1'b1, 1, 64'd4294836226),
      // length zero behaves as one
      reg_row(REG_INTEG_LEN, 0),
      sample_row(1, 2, 3, 4, 1'b0, 1, 30),
      sample_row(-1, -1, -1, -1, 1'b1, 1, 4),
      // four products, cross terms at both signs
      reg_row(REG_PRODUCT_MODE, 1),
      sample_row(32767, -32768, -32768, 32767, 1'b0, USE_PREDICTOR, 0),
      sample_row(-32768, -32768, -32768, -32768, 1'b0, USE_PREDICTOR, 0),
      sample_row(-1, 1, 1, -1, 1'b0, USE_PREDICTOR, 0),
      reg_row(REG_INTEG_LEN, 3),
      sample_row(100, -200, 300, -400, 1'b0, USE_PREDICTOR, 0),
      sample_row(-7, 13, 32767, -32768, 1'b0, USE_PREDICTOR, 0),
      sample_row(2000, 3000, -4000, 5000, 1'b1, USE_PREDICTOR, 0),
      // frame end inside a group throws the partial group away
      sample_row(5, 6, 7, 8, 1'b0, 0, 0),
      sample_row(-5, -6, -7, -8, 1'b1, 0, 0),
      // length lowered under the running count closes the group at once
      sample_row(11, -12, 13, -14, 1'b0, 0, 0),
      sample_row(-32768, 32767, 32767, -32768, 1'b0, 0, 0),
      reg_row(REG_INTEG_LEN, 1),
      sample_row(21, 22, -23, -24, 1'b0, USE_PREDICTOR, 0),
      // mode switched while a group is open
      reg_row(REG_INTEG_LEN, 2),
      sample_row(300, 400, 500, 600, 1'b0, 0, 0),
      reg_row(REG_PRODUCT_MODE, 0),
      sample_row(-300, 400, -500, 600, 1'b0, USE_PREDICTOR, 0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      s = directed[i];
      if (s.is_cfg) begin
        settle();
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        feed_sample(s.xr, s.xi, s.yr, s.yi, s.fend, 1'b1, s.typed_n, s.typed_total);
      end
    end

    // A length above the limit clamps to MAX_INTEGRATION: a short run of
    // full-scale samples keeps the group open and its frame end drops it.
    settle();
    write_reg(REG_PRODUCT_MODE, CFG_W'(1));
    write_reg(REG_INTEG_LEN, {LEN_W{1'b1}});
    for (int k = 0; k < CLAMP_ITEMS; k++)
      feed_sample(S_MIN, S_MIN, S_MIN, S_MIN, (k == CLAMP_ITEMS - 1), 1'b0,
                  USE_PREDICTOR, 0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == NUM_PHASES - 1) no_idle = 1'b1;
      mode_pick = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: len_pick = 0;
        1: len_pick = $urandom_range(9, 40);
        default: len_pick = $urandom_range(1, 8);
      endcase
      if (p == PRESSURE_PHASE) begin
        // short four-product groups pile up behind the held-off receiver
        mode_pick = 1'b1;
        len_pick  = 1;
      end
      if ($urandom_range(0, 1)) begin
        write_reg(REG_PRODUCT_MODE, CFG_W'(mode_pick));
        write_reg(REG_INTEG_LEN, CFG_W'(len_pick));
      end else begin
        write_reg(REG_INTEG_LEN, CFG_W'(len_pick));
        write_reg(REG_PRODUCT_MODE, CFG_W'(mode_pick));
      end
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
          // sender goes quiet until every owed result has drained
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_powers.size() != 0) @(posedge clk);
        end
        feed_sample(rand_field(), rand_field(), rand_field(), rand_field(),
                    ($urandom_range(0, 11) == 0), (p != PRESSURE_PHASE), USE_PREDICTOR, 0);
      end
    end

    in_valid <= 1'b0;
    drain_wait = 0;
    while (expected_powers.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    if (expected_powers.size() != 0)
      flag_mismatch("results never delivered", 0, longint'(expected_powers.size()));
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
